// ----- sv/srld_pkg.sv -----
package srld_pkg;

  // fixed field widths
  localparam int unsigned LedCountW = 11;
  localparam int unsigned TicksW    = 15;
  localparam int unsigned PixW      = 24;
  localparam int unsigned BitPosW   = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 15;

  // default store depth
  localparam int unsigned MaxLedsDefault = 1024;

  // bit position of the first bit sent from a loaded pixel
  localparam logic [BitPosW-1:0] TopBit = 5'd23;

  // register reset values
  localparam logic [LedCountW-1:0] LedCountRst = 11'd0;
  localparam logic [TicksW-1:0]    OneHighRst  = 15'd10;
  localparam logic [TicksW-1:0]    OneLowRst   = 15'd6;
  localparam logic [TicksW-1:0]    ZeroHighRst = 15'd4;
  localparam logic [TicksW-1:0]    ZeroLowRst  = 15'd8;
  localparam logic [TicksW-1:0]    LatchLowRst = 15'd50;

  // item kinds
  typedef enum logic [2:0] {
    KIND_WRITE_RGB   = 3'd0,
    KIND_WRITE_RED   = 3'd1,
    KIND_WRITE_GREEN = 3'd2,
    KIND_WRITE_BLUE  = 3'd3,
    KIND_READ        = 3'd4,
    KIND_SHOW        = 3'd5,
    KIND_TICK        = 3'd6
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LED_COUNT = 3'd0,
    REG_ONE_HIGH  = 3'd1,
    REG_ONE_LOW   = 3'd2,
    REG_ZERO_HIGH = 3'd3,
    REG_ZERO_LOW  = 3'd4,
    REG_LATCH_LOW = 3'd5
  } cfg_reg_e;

  // line phases
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_GAP  = 2'd3
  } phase_e;

  // pulse timing registers
  typedef struct packed {
    logic [TicksW-1:0] one_high;
    logic [TicksW-1:0] one_low;
    logic [TicksW-1:0] zero_high;
    logic [TicksW-1:0] zero_low;
    logic [TicksW-1:0] latch_low;
  } timing_t;

  // events handed to the line engine
  typedef struct packed {
    logic tick;
    logic show;
  } ev_t;

  // line engine status
  typedef struct packed {
    logic busy;
    logic busy_next;
    logic level;
    logic done;
  } eng_st_t;

endpackage

// ----- sv/srld_ram.sv -----
module srld_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AddrW-1:0] raddr_a_i,
  output logic [Width-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- sv/srld_line.sv -----
module srld_line #(
  parameter int unsigned MaxLeds = srld_pkg::MaxLedsDefault,
  localparam int unsigned AddrW = (MaxLeds > 1) ? $clog2(MaxLeds) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srld_pkg::ev_t                       ev_i,
  input  logic [srld_pkg::LedCountW-1:0]      active_i,
  input  srld_pkg::timing_t                   timing_i,
  input  logic [srld_pkg::PixW-1:0]           pix_a_i,
  input  logic [srld_pkg::PixW-1:0]           pix_pf_i,
  output logic [AddrW-1:0]                    pf_addr_o,
  output srld_pkg::eng_st_t                   st_o
);

  srld_pkg::phase_e                      phase_q, phase_d;
  logic [srld_pkg::PixW-1:0]             shift_q, shift_d;
  logic [srld_pkg::BitPosW-1:0]          bit_q, bit_d;
  logic [srld_pkg::LedCountW-1:0]        led_q, led_d;
  logic [srld_pkg::TicksW-1:0]           tl_q, tl_d;
  logic                                  pend_q, pend_d;

  logic [srld_pkg::TicksW-1:0]           tl_dec;
  logic [srld_pkg::LedCountW-1:0]        led_inc;
  logic [srld_pkg::LedCountW-1:0]        led_d_inc;
  logic                                  do_load;
  logic [srld_pkg::LedCountW-1:0]        ld_pos;
  logic [srld_pkg::PixW-1:0]             ld_pix;
  logic [srld_pkg::PixW-1:0]             ld_grb;

  function automatic logic [srld_pkg::TicksW-1:0] at_least_one(
    input logic [srld_pkg::TicksW-1:0] v
  );
    return (v == '0) ? srld_pkg::TicksW'(1) : v;
  endfunction

  assign tl_dec  = (tl_q != '0) ? tl_q - srld_pkg::TicksW'(1) : '0;
  assign led_inc = led_q + srld_pkg::LedCountW'(1);
  // stored order is red, green, blue; the line wants green first
  assign ld_grb  = {ld_pix[15:8], ld_pix[23:16], ld_pix[7:0]};

  // next state
  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    led_d   = led_q;
    tl_d    = tl_q;
    pend_d  = pend_q;
    do_load = 1'b0;
    ld_pos  = led_inc;
    ld_pix  = pix_pf_i;

    if (ev_i.show) begin
      if (phase_q == srld_pkg::PH_IDLE) begin
        do_load = 1'b1;
        ld_pos  = '0;
        ld_pix  = pix_a_i;
      end else begin
        pend_d = 1'b1;
      end
    end else if (ev_i.tick && (phase_q != srld_pkg::PH_IDLE)) begin
      tl_d = tl_dec;
      if (tl_dec == '0) begin
        case (phase_q)
          srld_pkg::PH_HIGH: begin
            phase_d = srld_pkg::PH_LOW;
            tl_d = at_least_one(shift_q[23] ? timing_i.one_low : timing_i.zero_low);
          end
          srld_pkg::PH_LOW: begin
            if (bit_q != '0) begin
              bit_d   = bit_q - srld_pkg::BitPosW'(1);
              shift_d = {shift_q[22:0], 1'b0};
              phase_d = srld_pkg::PH_HIGH;
              tl_d = at_least_one(shift_q[22] ? timing_i.one_high : timing_i.zero_high);
            end else begin
              do_load = 1'b1;
              ld_pos  = led_inc;
            end
          end
          srld_pkg::PH_GAP: begin
            if (pend_q) begin
              pend_d  = 1'b0;
              do_load = 1'b1;
              ld_pos  = '0;
            end else begin
              phase_d = srld_pkg::PH_IDLE;
              tl_d    = '0;
            end
          end
          default: begin
            phase_d = srld_pkg::PH_IDLE;
          end
        endcase
      end
    end

    // load the next led, or start the reset gap when none is left
    if (do_load) begin
      led_d = ld_pos;
      if (ld_pos < active_i) begin
        shift_d = ld_grb;
        bit_d   = srld_pkg::TopBit;
        phase_d = srld_pkg::PH_HIGH;
        tl_d = at_least_one(ld_grb[23] ? timing_i.one_high : timing_i.zero_high);
      end else begin
        phase_d = srld_pkg::PH_GAP;
        tl_d    = at_least_one(timing_i.latch_low);
      end
    end
  end

  // outputs and prefetch address for the next load
  assign led_d_inc = led_d + srld_pkg::LedCountW'(1);

  always_comb begin
    st_o.busy      = (phase_q != srld_pkg::PH_IDLE);
    st_o.busy_next = (phase_d != srld_pkg::PH_IDLE);
    st_o.level     = ev_i.tick && (phase_q == srld_pkg::PH_HIGH);
    st_o.done      = ev_i.tick && (phase_q == srld_pkg::PH_GAP) && (tl_dec == '0);
    if ((phase_d == srld_pkg::PH_IDLE) || (phase_d == srld_pkg::PH_GAP)) begin
      pf_addr_o = '0;
    end else begin
      pf_addr_o = AddrW'(led_d_inc);
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= srld_pkg::PH_IDLE;
      shift_q <= '0;
      bit_q   <= '0;
      led_q   <= '0;
      tl_q    <= '0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      bit_q   <= bit_d;
      led_q   <= led_d;
      tl_q    <= tl_d;
      pend_q  <= pend_d;
    end
  end

`ifndef SYNTHESIS
  // an idle line has no count running and no frame waiting
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == srld_pkg::PH_IDLE) |-> ((tl_q == '0) && !pend_q))
    else $error("idle line holds a tick count or a pending frame");

  // an active phase always has ticks left
  a_active_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != srld_pkg::PH_IDLE) |-> (tl_q != '0))
    else $error("active phase with zero ticks left");
`endif

endmodule

// ----- sv/serial_rgb_led_string_driver_core.sv -----
// Serial RGB LED string driver core.
// Input channel (in_valid_i / in_stall_o) takes one item per cycle while not stalled: pixel
// writes, reads, show requests and line ticks. Output channel (out_valid_o /
// out_stall_i) returns exactly one result item per input item, in order.
// From acceptance to result an item goes through the pixel memory read,
// registered with the execute stage, then execution into the output register.
// Throughput is one item per cycle while in_stall_o is low; each tick advances the line by one step.
// The pixel memory has one write port and two read ports: one for items,
// one that prefetches the next led of a running frame.
// A stalled receiver holds the output register; the execute stage then holds
// too and in_stall_o rises in the same cycle.
// Configuration writes (cfg_valid_i / cfg_ready_o) are registered and are to be made while
// no item is in flight; the user is bound to this, the block itself does not enforce it.
// After reset the pixel memory is cleared, one entry a cycle, from entry 0 to entry
// MaxLeds-1; in_stall_o stays high during that pass.
module serial_rgb_led_string_driver_core #(
  parameter int unsigned MaxLeds = srld_pkg::MaxLedsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        kind_i,
  input  logic [9:0]                        pixel_index_i,
  input  logic [7:0]                        red_in_i,
  input  logic [7:0]                        green_in_i,
  input  logic [7:0]                        blue_in_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              line_level_o,
  output logic                              busy_res_o,
  output logic [1:0]                        status_o,
  output logic [7:0]                        red_out_o,
  output logic [7:0]                        green_out_o,
  output logic [7:0]                        blue_out_o,
  output logic                              frame_done_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srld_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [srld_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned AddrW = (MaxLeds > 1) ? $clog2(MaxLeds) : 1;
  localparam logic [AddrW-1:0] ClrLast = AddrW'(MaxLeds - 1);

  // configuration registers
  logic [srld_pkg::LedCountW-1:0] led_count_q;
  srld_pkg::timing_t              timing_q;
  logic [srld_pkg::LedCountW-1:0] active_cnt;

  // clearing pass
  logic             clearing_q;
  logic [AddrW-1:0] clr_addr_q;

  // execute stage
  logic                   s1_valid_q;
  srld_pkg::kind_e        s1_kind_q;
  logic [9:0]             s1_idx_q;
  logic [7:0]             s1_red_q, s1_green_q, s1_blue_q;
  logic                   s1_fire;
  logic                   in_fire;
  logic [AddrW-1:0]       rd_addr_a;

  // forwarding of a write that overlaps the next read
  logic                        fwd_q;
  logic [srld_pkg::PixW-1:0]   fwd_data_q;

  // memory ports
  logic                        ram_we;
  logic [AddrW-1:0]            ram_waddr;
  logic [srld_pkg::PixW-1:0]   ram_wdata;
  logic [srld_pkg::PixW-1:0]   rdata_a;
  logic [srld_pkg::PixW-1:0]   rdata_b;
  logic [AddrW-1:0]            pf_addr;
  logic [srld_pkg::PixW-1:0]   pix_a;

  // item execution
  logic                        is_write;
  logic                        in_range;
  logic                        item_we;
  logic [srld_pkg::PixW-1:0]   item_wdata;
  srld_pkg::status_e           status_d;
  logic [srld_pkg::PixW-1:0]   rgb_d;
  srld_pkg::ev_t               ev;
  srld_pkg::eng_st_t           eng_st;

  // output register
  logic                        out_valid_q;
  logic                        out_level_q, out_busy_q, out_done_q;
  srld_pkg::status_e           out_status_q;
  logic [srld_pkg::PixW-1:0]   out_rgb_q;

  // configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q        <= srld_pkg::LedCountRst;
      timing_q.one_high  <= srld_pkg::OneHighRst;
      timing_q.one_low   <= srld_pkg::OneLowRst;
      timing_q.zero_high <= srld_pkg::ZeroHighRst;
      timing_q.zero_low  <= srld_pkg::ZeroLowRst;
      timing_q.latch_low <= srld_pkg::LatchLowRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (srld_pkg::cfg_reg_e'(cfg_index_i))
        srld_pkg::REG_LED_COUNT: led_count_q <= cfg_data_i[srld_pkg::LedCountW-1:0];
        srld_pkg::REG_ONE_HIGH:  timing_q.one_high  <= cfg_data_i;
        srld_pkg::REG_ONE_LOW:   timing_q.one_low   <= cfg_data_i;
        srld_pkg::REG_ZERO_HIGH: timing_q.zero_high <= cfg_data_i;
        srld_pkg::REG_ZERO_LOW:  timing_q.zero_low  <= cfg_data_i;
        srld_pkg::REG_LATCH_LOW: timing_q.latch_low <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // led count saturated to the store depth
  assign active_cnt = ((MaxLeds < (1 << srld_pkg::LedCountW)) && (led_count_q > MaxLeds))
                    ? srld_pkg::LedCountW'(MaxLeds) : led_count_q;

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == ClrLast) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // input handshake
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clearing_q || (s1_valid_q && !s1_fire);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign rd_addr_a  = (srld_pkg::kind_e'(kind_i) == srld_pkg::KIND_SHOW)
                    ? '0 : AddrW'(pixel_index_i);

  // execute stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= item_we && (AddrW'(s1_idx_q) == rd_addr_a);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q  <= srld_pkg::kind_e'(kind_i);
      s1_idx_q   <= pixel_index_i;
      s1_red_q   <= red_in_i;
      s1_green_q <= green_in_i;
      s1_blue_q  <= blue_in_i;
      fwd_data_q <= item_wdata;
    end
  end

  // pixel memory
  assign ram_we    = clearing_q || item_we;
  assign ram_waddr = clearing_q ? clr_addr_q : AddrW'(s1_idx_q);
  assign ram_wdata = clearing_q ? '0 : item_wdata;

  srld_ram #(
    .Width (srld_pkg::PixW),
    .Depth (MaxLeds)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_a_i    (in_fire),
    .raddr_a_i (rd_addr_a),
    .rdata_a_o (rdata_a),
    .re_b_i    (1'b1),
    .raddr_b_i (pf_addr),
    .rdata_b_o (rdata_b)
  );

  assign pix_a = fwd_q ? fwd_data_q : rdata_a;

  // item execution
  assign is_write = s1_kind_q inside {srld_pkg::KIND_WRITE_RGB, srld_pkg::KIND_WRITE_RED,
                                      srld_pkg::KIND_WRITE_GREEN, srld_pkg::KIND_WRITE_BLUE};
  assign in_range = ({1'b0, s1_idx_q} < active_cnt);
  assign item_we  = s1_fire && is_write && !eng_st.busy && in_range;

  always_comb begin
    case (s1_kind_q)
      srld_pkg::KIND_WRITE_RGB:   item_wdata = {s1_red_q, s1_green_q, s1_blue_q};
      srld_pkg::KIND_WRITE_RED:   item_wdata = {s1_red_q, pix_a[15:0]};
      srld_pkg::KIND_WRITE_GREEN: item_wdata = {pix_a[23:16], s1_green_q, pix_a[7:0]};
      srld_pkg::KIND_WRITE_BLUE:  item_wdata = {pix_a[23:8], s1_blue_q};
      default:                    item_wdata = pix_a;
    endcase
  end

  always_comb begin
    status_d = srld_pkg::ST_OK;
    rgb_d    = '0;
    if (is_write) begin
      if (eng_st.busy) begin
        status_d = srld_pkg::ST_BUSY;
      end else if (!in_range) begin
        status_d = srld_pkg::ST_RANGE;
      end
    end else if (s1_kind_q == srld_pkg::KIND_READ) begin
      if (in_range) begin
        rgb_d = pix_a;
      end else begin
        status_d = srld_pkg::ST_RANGE;
      end
    end
  end

  assign ev.tick = s1_fire && (s1_kind_q == srld_pkg::KIND_TICK);
  assign ev.show = s1_fire && (s1_kind_q == srld_pkg::KIND_SHOW);

  srld_line #(
    .MaxLeds (MaxLeds)
  ) u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ev_i      (ev),
    .active_i  (active_cnt),
    .timing_i  (timing_q),
    .pix_a_i   (pix_a),
    .pix_pf_i  (rdata_b),
    .pf_addr_o (pf_addr),
    .st_o      (eng_st)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_level_q  <= eng_st.level;
      out_busy_q   <= eng_st.busy_next;
      out_done_q   <= eng_st.done;
      out_status_q <= status_d;
      out_rgb_q    <= rgb_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = out_level_q;
  assign busy_res_o   = out_busy_q;
  assign status_o     = out_status_q;
  assign red_out_o    = out_rgb_q[23:16];
  assign green_out_o  = out_rgb_q[15:8];
  assign blue_out_o   = out_rgb_q[7:0];
  assign frame_done_o = out_done_q;

`ifndef SYNTHESIS
  // no pixel write lands while a frame is on the line
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_we |-> !eng_st.busy)
    else $error("pixel write while frame in progress");

  // the tick that ends a frame drives the line low
  a_done_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> !out_level_q)
    else $error("frame end with line high");

  // the clearing pass covers every entry
  a_clear_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> ($past(clr_addr_q) == ClrLast))
    else $error("clearing pass ended early");
`endif

endmodule
